// ===== src/sound_distance_bearing_defines.svh =====
// ----------------------------------------------------------------------------
// Sound distance and bearing: assertion macros
// Shared assertion macros for the sound distance and bearing block.
// ----------------------------------------------------------------------------
`ifndef SOUND_DISTANCE_BEARING_DEFINES_SVH
`define SOUND_DISTANCE_BEARING_DEFINES_SVH

`ifndef SYNTH

`define SDB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sound_distance_bearing: assertion failed");

`define SDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sound_distance_bearing: assertion failed");

`else

`define SDB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SDB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/sdb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sound distance and bearing package
// Types, widths and constant tables shared by the pipeline modules.
// ----------------------------------------------------------------------------
package sdb_pkg;

   localparam int FieldW      = 8;
   localparam int BearingW    = 16;
   localparam int DivStages   = 5;

   localparam int LvlDivW     = 17;
   localparam int LvlSteps    = 3;
   localparam int LvlQuoW     = LvlSteps * DivStages;

   localparam int RatDivW     = 8;
   localparam int RatSteps    = 4;
   localparam int RatQuoW     = RatSteps * DivStages;
   localparam int RatioW      = 16;

   localparam int NumThresh   = 8;
   localparam int IdxW        = $clog2(NumThresh);

   localparam logic [BearingW-1:0] BearingAxisX = 16'h8000;
   localparam logic [BearingW-1:0] BearingAxisY = 16'hF800;

   localparam logic [RatioW-1:0] RatioThresh [NumThresh] = '{
      16'h25A0, 16'h11F0, 16'h0B00, 16'h0730,
      16'h0490, 16'h0290, 16'h00D0, 16'h0000
   };

   localparam logic [BearingW-1:0] BearingCode [NumThresh] = '{
      16'hF800, 16'hE900, 16'hDA00, 16'hCB00,
      16'hBC00, 16'hAD00, 16'h9E00, 16'h8F00
   };

   typedef struct packed {
      logic [LvlDivW-1:0] lvl_rem;
      logic [LvlQuoW-1:0] lvl_quo;
      logic [LvlDivW-1:0] lvl_div;
      logic [RatDivW-1:0] rat_rem;
      logic [RatQuoW-1:0] rat_quo;
      logic [RatDivW-1:0] rat_div;
      logic               x_zero;
      logic               y_zero;
   } work_type;

endpackage

// ===== src/sdb_front.sv =====
// ----------------------------------------------------------------------------
// Sound distance and bearing: front stage
// Registers an item with its squared distance and sets up both dividers.
// ----------------------------------------------------------------------------
module sdb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [sdb_pkg::FieldW-1:0]  in_loudness,
   input  logic [sdb_pkg::FieldW-1:0]  in_offset_x,
   input  logic [sdb_pkg::FieldW-1:0]  in_offset_y,
   output logic                        out_valid,
   input  logic                        out_ready,
   output sdb_pkg::work_type           out_work
);
   import sdb_pkg::*;

   logic                 valid_ff;
   work_type             work_ff;
   work_type             work_in;
   logic [2*FieldW-1:0]  sq_x;
   logic [2*FieldW-1:0]  sq_y;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sq_x = (2*FieldW)'(in_offset_x) * (2*FieldW)'(in_offset_x);
      sq_y = (2*FieldW)'(in_offset_y) * (2*FieldW)'(in_offset_y);
      work_in.lvl_rem = '0;
      work_in.lvl_quo = LvlQuoW'({in_loudness, 3'b000});
      work_in.lvl_div = LvlDivW'(sq_x) + LvlDivW'(sq_y) + LvlDivW'(8);
      work_in.rat_rem = '0;
      work_in.rat_quo = RatQuoW'({in_offset_x, 11'b0});
      work_in.rat_div = in_offset_y;
      work_in.x_zero  = (in_offset_x == '0);
      work_in.y_zero  = (in_offset_y == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ===== src/sdb_div_stage.sv =====
// ----------------------------------------------------------------------------
// Sound distance and bearing: divider stage
// Runs three level steps and four ratio steps of restoring division on the quotients.
// ----------------------------------------------------------------------------
`include "sound_distance_bearing_defines.svh"

module sdb_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sdb_pkg::work_type in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output sdb_pkg::work_type out_work
);
   import sdb_pkg::*;

   logic     valid_ff;
   work_type work_ff;
   work_type work_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic [LvlDivW:0] lvl_t;
      logic [RatDivW:0] rat_t;
      work_in = in_work;
      for (int i = 0; i < LvlSteps; i++) begin
         lvl_t = {work_in.lvl_rem, work_in.lvl_quo[LvlQuoW-1]};
         if (lvl_t >= {1'b0, work_in.lvl_div}) begin
            work_in.lvl_rem = LvlDivW'(lvl_t - {1'b0, work_in.lvl_div});
            work_in.lvl_quo = {work_in.lvl_quo[LvlQuoW-2:0], 1'b1};
         end else begin
            work_in.lvl_rem = lvl_t[LvlDivW-1:0];
            work_in.lvl_quo = {work_in.lvl_quo[LvlQuoW-2:0], 1'b0};
         end
      end
      for (int i = 0; i < RatSteps; i++) begin
         rat_t = {work_in.rat_rem, work_in.rat_quo[RatQuoW-1]};
         if (rat_t >= {1'b0, work_in.rat_div}) begin
            work_in.rat_rem = RatDivW'(rat_t - {1'b0, work_in.rat_div});
            work_in.rat_quo = {work_in.rat_quo[RatQuoW-2:0], 1'b1};
         end else begin
            work_in.rat_rem = rat_t[RatDivW-1:0];
            work_in.rat_quo = {work_in.rat_quo[RatQuoW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   // Partial remainders must stay below their divisors (ratio only for nonzero y); the level divisor is at least 8.
   `SDB_ASSERT_IMPL(a_lvl_rem, clock, reset, valid_ff, work_ff.lvl_rem < work_ff.lvl_div)
   `SDB_ASSERT_IMPL(a_rat_rem, clock, reset, valid_ff && !work_ff.y_zero,
                    work_ff.rat_rem < work_ff.rat_div)
   `SDB_ASSERT_IMPL(a_lvl_div_min, clock, reset, valid_ff,
                    work_ff.lvl_div >= LvlDivW'(8))

endmodule

// ===== src/sdb_bearing.sv =====
// ----------------------------------------------------------------------------
// Sound distance and bearing: result stage
// Classifies the ratio into a bearing code and registers the result item.
// ----------------------------------------------------------------------------
module sdb_bearing (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  sdb_pkg::work_type             in_work,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [sdb_pkg::FieldW-1:0]    out_level,
   output logic [sdb_pkg::BearingW-1:0]  out_bearing
);
   import sdb_pkg::*;

   logic                valid_ff;
   logic [FieldW-1:0]   level_ff;
   logic [FieldW-1:0]   level_in;
   logic [BearingW-1:0] bearing_ff;
   logic [BearingW-1:0] bearing_in;
   logic [RatioW-1:0]   ratio;
   logic [IdxW-1:0]     idx;

   assign in_ready = !valid_ff || out_ready;
   assign ratio    = in_work.rat_quo[RatioW-1:0];
   assign level_in = in_work.lvl_quo[FieldW-1:0];

   always_comb begin
      idx = IdxW'(NumThresh - 1);
      for (int i = NumThresh - 1; i >= 0; i--) begin
         if (ratio >= RatioThresh[i]) begin
            idx = IdxW'(i);
         end
      end
      if (in_work.x_zero) begin
         bearing_in = BearingAxisX;
      end else if (in_work.y_zero) begin
         bearing_in = BearingAxisY;
      end else begin
         bearing_in = BearingCode[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         level_ff   <= level_in;
         bearing_ff <= bearing_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_level   = level_ff;
   assign out_bearing = bearing_ff;

endmodule

// ===== src/sound_distance_bearing.sv =====
// ----------------------------------------------------------------------------
// Sound distance and bearing
// Distance attenuation and quantized direction code for one positional sound.
// ----------------------------------------------------------------------------
// An accepted item passes the front register, the five divider stages and the
// result register. Throughput is one item per cycle while rsp_stall is low;
// every divider stage runs three level steps and four ratio steps of restoring division.
// Reset clears all stage valid bits, which empties the pipeline.
`include "sound_distance_bearing_defines.svh"

module sound_distance_bearing (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sdb_pkg::FieldW-1:0]    req_loudness,
   input  logic [sdb_pkg::FieldW-1:0]    req_offset_x,
   input  logic [sdb_pkg::FieldW-1:0]    req_offset_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sdb_pkg::FieldW-1:0]    rsp_level,
   output logic [sdb_pkg::BearingW-1:0]  rsp_bearing
);
   import sdb_pkg::*;

   logic     stg_valid [DivStages+1];
   logic     stg_ready [DivStages+1];
   work_type stg_work  [DivStages+1];
   logic     front_ready;

   assign req_stall = !front_ready;

   sdb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (front_ready),
      .in_loudness (req_loudness),
      .in_offset_x (req_offset_x),
      .in_offset_y (req_offset_y),
      .out_valid   (stg_valid[0]),
      .out_ready   (stg_ready[0]),
      .out_work    (stg_work[0])
   );

   for (genvar g = 0; g < DivStages; g++) begin : g_div
      sdb_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_ready  (stg_ready[g]),
         .in_work   (stg_work[g]),
         .out_valid (stg_valid[g+1]),
         .out_ready (stg_ready[g+1]),
         .out_work  (stg_work[g+1])
      );
   end

   sdb_bearing u_bearing (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stg_valid[DivStages]),
      .in_ready    (stg_ready[DivStages]),
      .in_work     (stg_work[DivStages]),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_level   (rsp_level),
      .out_bearing (rsp_bearing)
   );

   // Input side stalls only when every stage holds an item and the output waits.
   `SDB_ASSERT_IMPL(a_stall_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `SDB_ASSERT_IMPL(a_bearing_code, clock, reset, rsp_valid,
                    rsp_bearing == BearingAxisX || rsp_bearing == 16'h8F00 ||
                    rsp_bearing == 16'h9E00 || rsp_bearing == 16'hAD00 ||
                    rsp_bearing == 16'hBC00 || rsp_bearing == 16'hCB00 ||
                    rsp_bearing == 16'hDA00 || rsp_bearing == 16'hE900 ||
                    rsp_bearing == 16'hF800)
   `SDB_ASSERT_NEXT(a_drain, clock, reset, stg_valid[DivStages] && !rsp_stall, rsp_valid)

endmodule
